// File: hw/rtl/hnsf_pkg.sv
// Shared types and constants for the HDLC NRZI bit-stuffing FCS transmitter.
package hnsf_pkg;

  localparam int unsigned StuffRun   = 5;
  localparam int unsigned MaxResults = 20;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl = 16'h8408;

  localparam logic [1:0] ModeFlag  = 2'd0;
  localparam logic [1:0] ModeData  = 2'd1;
  localparam logic [1:0] ModeClose = 2'd2;

  typedef struct packed {
    logic clear;
    logic feed;
    logic bit_val;
  } crc_ctrl_t;

endpackage

// File: hw/rtl/hnsf_crc.sv
// Serial reflected CRC-16 register, fed one bit per cycle while feed is set.
module hnsf_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hnsf_pkg::crc_ctrl_t ctrl_i,
  output logic [15:0]       crc_o
);

  logic [15:0] crc_q, crc_d;
  logic        fb;

  always_comb begin
    fb    = crc_q[0] ^ ctrl_i.bit_val;
    crc_d = crc_q;
    if (ctrl_i.clear) begin
      crc_d = hnsf_pkg::CrcInit;
    end else if (ctrl_i.feed) begin
      crc_d = {1'b0, crc_q[15:1]} ^ (fb ? hnsf_pkg::CrcPolyRefl : 16'h0000);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= hnsf_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// File: hw/rtl/hdlc_nrzi_stuff_fcs_tx.sv
// Top level of the HDLC transmitter with bit stuffing, FCS and NRZI tone choice.
//
// Requests arrive on the input channel (in_valid_i, in_ready_o) with a mode
// and a byte: a flag byte goes out as is, a data byte is fed into the FCS and
// bit-stuffed, and a close-frame request sends the inverted FCS, stuffed, low
// bit first. Each bit period leaves on the output channel (out_valid_o,
// out_ready_i) as a tone choice, a stuffing mark and a last-bit mark.
// After acceptance the shift register is loaded; then the bit sequencer
// produces one bit period per cycle, while the receiver does not stall,
// through a single output register. A request yields one bit period per bit
// plus one per stuffing zero, and a request in the unused mode yields no
// result. The input is not ready while a request is in progress, and it
// becomes ready again at the same edge that loads the last period into the
// output register.
// When the receiver stalls, the output register holds its result and the
// sequencer waits. Reset clears the FCS register to all ones, the ones count
// to zero and the tone to low, and empties the output register.
module hdlc_nrzi_stuff_fcs_tx (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tone_high_o,
  output logic       stuffed_o,
  output logic       last_bit_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                      state_q, state_d;
  logic [1:0]                mode_q, mode_d;
  logic [15:0]               sr_q, sr_d;
  logic [4:0]                left_q, left_d;
  logic                      pend_q, pend_d;
  logic [hnsf_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [2:0]                ones_q, ones_d;
  logic                      tone_q, tone_d;
  logic                      ov_q, ov_d;
  logic                      ot_q, ot_d, os_q, os_d, ol_q, ol_d;

  logic                      accept, step, bit_val, is_stuff, done, emit;
  logic [2:0]                ones_inc;
  logic [15:0]               crc;
  hnsf_pkg::crc_ctrl_t       crc_ctrl;

  hnsf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_q == StRun) && (!ov_q || out_ready_i);
  assign emit       = (cnt_q != hnsf_pkg::CntW'(hnsf_pkg::MaxResults));
  assign ones_inc   = ones_q + 3'd1;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    sr_d     = sr_q;
    left_d   = left_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    ones_d   = ones_q;
    tone_d   = tone_q;
    ov_d     = ov_q && !out_ready_i;
    ot_d     = ot_q;
    os_d     = os_q;
    ol_d     = ol_q;
    bit_val  = 1'b0;
    is_stuff = 1'b0;
    done     = 1'b0;
    crc_ctrl = '{clear: 1'b0, feed: 1'b0, bit_val: 1'b0};

    if (accept) begin
      mode_d = mode_i;
      cnt_d  = '0;
      pend_d = 1'b0;
      case (mode_i)
        hnsf_pkg::ModeFlag, hnsf_pkg::ModeData: begin
          state_d = StRun;
          sr_d    = {8'h00, data_byte_i};
          left_d  = 5'd8;
        end
        hnsf_pkg::ModeClose: begin
          state_d = StRun;
          sr_d    = ~crc;
          left_d  = 5'd16;
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end else if (step) begin
      if (pend_q) begin
        bit_val  = 1'b0;
        is_stuff = 1'b1;
        pend_d   = 1'b0;
        ones_d   = '0;
      end else begin
        bit_val = sr_q[0];
        sr_d    = {1'b0, sr_q[15:1]};
        left_d  = left_q - 5'd1;
        if (mode_q != hnsf_pkg::ModeFlag) begin
          if (bit_val) begin
            ones_d = ones_inc;
            pend_d = (32'(ones_inc) >= hnsf_pkg::StuffRun);
          end else begin
            ones_d = '0;
          end
        end
        if (mode_q == hnsf_pkg::ModeData) begin
          crc_ctrl.feed    = 1'b1;
          crc_ctrl.bit_val = bit_val;
        end
      end
      tone_d = tone_q ^ ~bit_val;
      done   = (left_d == 5'd0) && !pend_d;
      if (emit) begin
        cnt_d = cnt_q + hnsf_pkg::CntW'(1);
        ov_d  = 1'b1;
        ot_d  = tone_d;
        os_d  = is_stuff;
        ol_d  = done || (cnt_q == hnsf_pkg::CntW'(hnsf_pkg::MaxResults - 1));
      end
      if (done) begin
        state_d = StIdle;
        if (mode_q == hnsf_pkg::ModeFlag) begin
          crc_ctrl.clear = 1'b1;
          ones_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      ones_q  <= '0;
      tone_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      ones_q  <= ones_d;
      tone_q  <= tone_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    sr_q   <= sr_d;
    left_q <= left_d;
    ot_q   <= ot_d;
    os_q   <= os_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign tone_high_o = ot_q;
  assign stuffed_o   = os_q;
  assign last_bit_o  = ol_q;

  a_stuff_not_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (mode_q != hnsf_pkg::ModeFlag))
    else $error("stuffing pending during a flag byte");

  a_ones_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (32'(ones_q) < hnsf_pkg::StuffRun))
    else $error("ones run reached the stuffing limit without a stuff bit");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= hnsf_pkg::MaxResults)
    else $error("result count beyond its limit");

  a_stuff_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && pend_q) |=> (tone_q != $past(tone_q)))
    else $error("stuffing zero did not toggle the tone");

endmodule

// File: sim/hdlc_tx_bit_checker.sv
// Checker that predicts and compares the bit periods of the HDLC NRZI transmitter.
module hdlc_tx_bit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        data_byte_i,
  input  logic              bit_valid_i,
  input  logic              bit_ready_i,
  input  logic              tone_high_i,
  input  logic              stuffed_i,
  input  logic              last_bit_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       periods_seen_o
);

  typedef struct packed {
    logic tone;
    logic stuffed;
    logic last;
  } period_t;

  period_t     expected_q[$];
  period_t     frame_q[$];
  period_t     want;
  logic [15:0] fcs_acc;
  logic [2:0]  ones_cnt;
  logic        tone_now;
  int unsigned fails   = 0;
  int unsigned checked = 0;

  task automatic emit_period(input logic line_val, input logic is_stuff);
    period_t p;
    if (!line_val) tone_now = ~tone_now;
    p.tone    = tone_now;
    p.stuffed = is_stuff;
    p.last    = 1'b0;
    if (frame_q.size() < hnsf_pkg::MaxResults) frame_q.push_back(p);
  endtask

  task automatic emit_stuffed(input logic line_val);
    emit_period(line_val, 1'b0);
    if (line_val) begin
      ones_cnt = ones_cnt + 3'd1;
      if (ones_cnt >= hnsf_pkg::StuffRun) begin
        emit_period(1'b0, 1'b1);
        ones_cnt = '0;
      end
    end else begin
      ones_cnt = '0;
    end
  endtask

  task automatic predict_request(input logic [1:0] mode, input logic [7:0] octet);
    logic [15:0] fcs;
    logic        fb;
    period_t     p;
    frame_q.delete();
    case (mode)
      hnsf_pkg::ModeFlag: begin
        for (int i = 0; i < 8; i++) emit_period(octet[i], 1'b0);
        fcs_acc  = hnsf_pkg::CrcInit;
        ones_cnt = '0;
      end
      hnsf_pkg::ModeData: begin
        for (int i = 0; i < 8; i++) begin
          fb      = fcs_acc[0] ^ octet[i];
          fcs_acc = {1'b0, fcs_acc[15:1]} ^ (fb ? hnsf_pkg::CrcPolyRefl : 16'h0000);
          emit_stuffed(octet[i]);
        end
      end
      hnsf_pkg::ModeClose: begin
        fcs = ~fcs_acc;
        for (int i = 0; i < 16; i++) emit_stuffed(fcs[i]);
      end
      default: ;
    endcase
    if (frame_q.size() > 0) begin
      p      = frame_q.pop_back();
      p.last = 1'b1;
      frame_q.push_back(p);
    end
    while (frame_q.size() > 0) expected_q.push_back(frame_q.pop_front());
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_acc  = hnsf_pkg::CrcInit;
      ones_cnt = '0;
      tone_now = 1'b0;
      expected_q.delete();
    end else begin
      if (bit_valid_i && bit_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("bit period with nothing expected: tone_high=%0b stuffed=%0b last_bit=%0b",
                 tone_high_i, stuffed_i, last_bit_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (tone_high_i !== want.tone) begin
            $error("tone_high: expected %0b, got %0b", want.tone, tone_high_i);
            fails++;
          end
          if (stuffed_i !== want.stuffed) begin
            $error("stuffed: expected %0b, got %0b", want.stuffed, stuffed_i);
            fails++;
          end
          if (last_bit_i !== want.last) begin
            $error("last_bit: expected %0b, got %0b", want.last, last_bit_i);
            fails++;
          end
          checked++;
        end
      end
      if (req_valid_i && req_ready_i) predict_request(mode_i, data_byte_i);
    end
    pending_o      <= expected_q.size();
    fail_count_o   <= fails;
    periods_seen_o <= checked;
  end

endmodule

// File: sim/tb_hdlc_nrzi_stuff_fcs_tx.sv
// Testbench top that drives requests into the HDLC NRZI transmitter and gives the verdict.
module tb_hdlc_nrzi_stuff_fcs_tx;

  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        tone_high;
  logic        stuffed;
  logic        last_bit;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned periods_seen;
  int unsigned idle_pct;
  int unsigned n_flag;
  int unsigned n_data;
  int unsigned n_close;
  int unsigned n_unused;

  hdlc_nrzi_stuff_fcs_tx i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .tone_high_o (tone_high),
    .stuffed_o   (stuffed),
    .last_bit_o  (last_bit)
  );

  hdlc_tx_bit_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid),
    .req_ready_i    (in_ready),
    .mode_i         (mode),
    .data_byte_i    (data_byte),
    .bit_valid_i    (out_valid),
    .bit_ready_i    (out_ready),
    .tone_high_i    (tone_high),
    .stuffed_i      (stuffed),
    .last_bit_i     (last_bit),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .periods_seen_o (periods_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #500000;
    $display("CHECK FAILED");
    $finish;
  end

  // Runs of ones are favoured so that stuffing happens often.
  function automatic logic [7:0] rand_octet();
    if ($urandom_range(0, 3) == 0) return 8'hFF ^ (8'h01 << $urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic issue_request(input logic [1:0] m, input logic [7:0] octet);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= octet;
    do @(posedge clk_i); while (!in_ready);
    case (m)
      hnsf_pkg::ModeFlag:  n_flag++;
      hnsf_pkg::ModeData:  n_data++;
      hnsf_pkg::ModeClose: n_close++;
      default:             n_unused++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    int pick;
    int nbytes;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    mode      <= hnsf_pkg::ModeFlag;
    data_byte <= 8'h00;
    idle_pct   = 20;
    n_flag     = 0;
    n_data     = 0;
    n_close    = 0;
    n_unused   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_request(hnsf_pkg::ModeFlag, 8'h7E);
    issue_request(hnsf_pkg::ModeData, 8'h00);
    issue_request(hnsf_pkg::ModeData, 8'hFF);
    issue_request(hnsf_pkg::ModeData, 8'hFF);
    issue_request(hnsf_pkg::ModeClose, 8'h00);
    issue_request(hnsf_pkg::ModeFlag, 8'h7E);
    issue_request(hnsf_pkg::ModeData, 8'h01);
    issue_request(hnsf_pkg::ModeData, 8'h80);
    issue_request(hnsf_pkg::ModeData, 8'h1F);
    issue_request(hnsf_pkg::ModeData, 8'hF8);
    issue_request(hnsf_pkg::ModeData, 8'h55);
    issue_request(hnsf_pkg::ModeData, 8'hAA);
    issue_request(hnsf_pkg::ModeClose, 8'hFF);
    issue_request(hnsf_pkg::ModeFlag, 8'h00);
    issue_request(hnsf_pkg::ModeFlag, 8'hFF);
    issue_request(hnsf_pkg::ModeData, 8'h3E);
    issue_request(ModeUnused, 8'hA5);
    issue_request(ModeUnused, 8'h5A);
    issue_request(hnsf_pkg::ModeClose, 8'h00);
    issue_request(hnsf_pkg::ModeClose, 8'h00);
    issue_request(hnsf_pkg::ModeFlag, 8'h7E);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 50 : 0;
      while (n_flag + n_data + n_close < 20 + (ph + 1) * 65) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          repeat ($urandom_range(1, 2)) issue_request(hnsf_pkg::ModeFlag, 8'h7E);
          nbytes = $urandom_range(0, 10);
          repeat (nbytes) issue_request(hnsf_pkg::ModeData, rand_octet());
          issue_request(hnsf_pkg::ModeClose, 8'($urandom));
        end else if (pick == 8) begin
          issue_request(ModeUnused, 8'($urandom));
        end else begin
          issue_request(2'($urandom_range(0, 2)), rand_octet());
        end
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    $display("Sent %0d flag, %0d data and %0d close requests and %0d in the unused mode.",
             n_flag, n_data, n_close, n_unused);
    $display("Checked %0d bit periods under random stalls on both channels.", periods_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: hdlc_nrzi_stuff_fcs_tx.f
hw/rtl/hnsf_pkg.sv
hw/rtl/hnsf_crc.sv
hw/rtl/hdlc_nrzi_stuff_fcs_tx.sv
sim/hdlc_tx_bit_checker.sv
sim/tb_hdlc_nrzi_stuff_fcs_tx.sv
